### hw/rtl/pstbl_pkg.sv
// Shared types, codes and constants of the per-source token bucket limiter.
`timescale 1ns / 1ps
package pstbl_pkg;

   // Table geometry defaults.
   localparam int DEF_TABLE_SLOTS = 4096;
   localparam int DEF_TABLE_WAYS  = 4;

   // Field widths.
   localparam int MODE_W   = 2;
   localparam int FAMILY_W = 2;
   localparam int ADDR_W   = 64;
   localparam int TIME_W   = 48;
   localparam int OUTC_W   = 2;
   localparam int KIND_W   = 2;
   localparam int KEY_W    = 64;
   localparam int TOKEN_W  = 34;
   localparam int CONN_W   = 8;
   localparam int RATE_W   = 16;
   localparam int BURST_W  = 17;
   localparam int HASH_W   = 32;
   localparam int STEP_W   = 5;
   localparam int HALF_T_W = 24;
   localparam int PROD_W   = 40;
   localparam int ADD_W    = 64;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;
   localparam logic [CSR_IDX_W-1:0] CSR_REFILL_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BURST_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CONNS   = 2'd2;
   localparam logic [CONN_W-1:0]    MAX_CONNS_RESET = 8'd16;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_QUERY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

   // Address families.
   localparam logic [FAMILY_W-1:0] FAM_V4 = 2'd0;
   localparam logic [FAMILY_W-1:0] FAM_V6 = 2'd1;

   // Slot kinds.
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_V4    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_V6    = 2'd2;

   // Outcome codes.
   localparam logic [OUTC_W-1:0] OUTC_EXISTING = 2'd0;
   localparam logic [OUTC_W-1:0] OUTC_NEW      = 2'd1;
   localparam logic [OUTC_W-1:0] OUTC_NO_SLOT  = 2'd2;
   localparam logic [OUTC_W-1:0] OUTC_BYPASS   = 2'd3;

   // Hash and token constants.
   localparam logic [HASH_W-1:0]  FNV_BASIS = 32'd2166136261;
   localparam logic [HASH_W-1:0]  FNV_PRIME = 32'd16777619;
   localparam logic [TOKEN_W-1:0] ONE_TOKEN = 34'd65536;
   localparam logic [STEP_W-1:0]  V4_LAST_BYTE  = 5'd3;
   localparam logic [STEP_W-1:0]  V6_LAST_BYTE  = 5'd15;
   localparam logic [STEP_W-1:0]  MOD_LAST_STEP = 5'd31;

   // One table entry.
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [KEY_W-1:0]   key;
      logic [TOKEN_W-1:0] tokens;
      logic [TIME_W-1:0]  last_time;
      logic [CONN_W-1:0]  conns;
   } entry_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_MOD,
      ST_READ,
      ST_SCAN,
      ST_DECIDE,
      ST_ELAPSED,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_SAT,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic ready;
      logic load;
      logic step_clr;
      logic hash_step;
      logic mod_step;
      logic read;
      logic scan_step;
      logic decide;
      logic elapsed;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic sat;
      logic mem_write;
      logic emit;
      logic clr_start;
      logic clr_write;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic req_valid;
      logic bypass;
      logic cfg_hit;
      logic hash_last;
      logic mod_last;
      logic scan_last;
      logic sets_pow2;
      logic need_bucket;
      logic need_write;
      logic out_free;
      logic clr_last;
   } dp_status_type;

endpackage

### hw/rtl/pstbl_ifs.sv
// Request and response channel interfaces of the limiter.
`timescale 1ns / 1ps
interface pstbl_req_if;
   import pstbl_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [FAMILY_W-1:0] family;
   logic [ADDR_W-1:0]   addr_hi;
   logic [ADDR_W-1:0]   addr_lo;
   logic [TIME_W-1:0]   now_time;
   modport source (output valid, mode, family, addr_hi, addr_lo, now_time, input ready);
   modport sink (input valid, mode, family, addr_hi, addr_lo, now_time, output ready);
endinterface

interface pstbl_rsp_if;
   import pstbl_pkg::*;
   logic              valid;
   logic              ready;
   logic              allowed;
   logic [OUTC_W-1:0] outcome;
   modport source (output valid, allowed, outcome, input ready);
   modport sink (input valid, allowed, outcome, output ready);
endinterface

### hw/rtl/pstbl_ctrl.sv
// Controller state machine that sequences one word through the datapath.
`timescale 1ns / 1ps
module pstbl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  pstbl_pkg::dp_status_type status,
   output pstbl_pkg::dp_cmd_type    cmd
);
   import pstbl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register; reset starts with a table clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (status.req_valid) state_in = status.bypass ? ST_DONE : ST_HASH;
         end
         ST_HASH: begin
            if (status.hash_last) state_in = status.sets_pow2 ? ST_READ : ST_MOD;
         end
         ST_MOD: begin
            if (status.mod_last) state_in = ST_READ;
         end
         ST_READ:    state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (status.need_bucket) state_in = ST_ELAPSED;
            else if (status.need_write)      state_in = ST_WRITE;
            else                             state_in = ST_DONE;
         end
         ST_ELAPSED: state_in = ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_MUL_HI;
         ST_MUL_HI:  state_in = ST_SUM;
         ST_SUM:     state_in = ST_SAT;
         ST_SAT:     state_in = ST_WRITE;
         ST_WRITE:   state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_CLEAR;
      endcase
      // A register write restarts the clearing pass from any state.
      if (status.cfg_hit) state_in = ST_CLEAR;
   end

   // Command outputs.
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR:   cmd.clr_write = 1'b1;
         ST_IDLE: begin
            cmd.ready    = 1'b1;
            cmd.load     = status.req_valid;
            cmd.step_clr = 1'b1;
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            cmd.step_clr  = status.hash_last;
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            cmd.step_clr = status.mod_last;
         end
         ST_READ: begin
            cmd.read     = 1'b1;
            cmd.step_clr = 1'b1;
         end
         ST_SCAN:    cmd.scan_step = 1'b1;
         ST_DECIDE:  cmd.decide    = 1'b1;
         ST_ELAPSED: cmd.elapsed   = 1'b1;
         ST_MUL_LO:  cmd.mul_lo    = 1'b1;
         ST_MUL_HI:  cmd.mul_hi    = 1'b1;
         ST_SUM:     cmd.sum       = 1'b1;
         ST_SAT:     cmd.sat       = 1'b1;
         ST_WRITE:   cmd.mem_write = 1'b1;
         ST_DONE:    cmd.emit      = status.out_free;
         default:    cmd = '0;
      endcase
      cmd.clr_start = status.cfg_hit;
   end

endmodule

### hw/rtl/pstbl_dp.sv
// Datapath: key hashing, set table memory, way scan, token bucket and output register.
`timescale 1ns / 1ps
module pstbl_dp #(
   parameter int TABLE_SLOTS = pstbl_pkg::DEF_TABLE_SLOTS,
   parameter int TABLE_WAYS  = pstbl_pkg::DEF_TABLE_WAYS
) (
   input  logic                                clock,
   input  logic                                reset,
   pstbl_req_if.sink                           req_if,
   pstbl_rsp_if.source                         rsp_if,
   input  logic                                csr_we,
   input  logic [pstbl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pstbl_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  pstbl_pkg::dp_cmd_type               cmd,
   output pstbl_pkg::dp_status_type            status
);
   import pstbl_pkg::*;

   localparam int SETS   = TABLE_SLOTS / TABLE_WAYS;
   localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int REM_W  = SET_AW + 1;
   localparam int WAY_W  = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);

   typedef entry_type [TABLE_WAYS-1:0] row_type;

   // Configuration registers.
   logic [RATE_W-1:0]  rate_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [CONN_W-1:0]  max_conns_ff;
   logic               cfg_hit;

   // Item registers.
   logic [MODE_W-1:0]  mode_ff;
   logic [KIND_W-1:0]  kind_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [HASH_W-1:0]  hash_ff;
   logic [SET_AW-1:0]  rem_ff;
   logic [SET_AW-1:0]  set_ff;
   logic [SET_AW-1:0]  clr_ff;

   // Table memory and the registered read row.
   row_type mem [SETS];
   row_type row_ff;
   row_type wrow;

   // Scan results.
   logic              found_ff, empty_found_ff, idle_found_ff;
   logic [WAY_W-1:0]  hit_way_ff, empty_way_ff, idle_way_ff;
   logic [TIME_W-1:0] idle_last_ff;

   // Working entry and bucket arithmetic.
   entry_type          ent_ff;
   logic [WAY_W-1:0]   way_ff;
   logic [TIME_W-1:0]  elapsed_ff;
   logic [PROD_W-1:0]  plo_ff, phi_ff;
   logic [ADD_W-1:0]   add_ff;
   logic               allowed_ff;
   logic [OUTC_W-1:0]  outcome_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_allowed_ff;
   logic [OUTC_W-1:0] rsp_outcome_ff;

   // Combinational helpers.
   logic               in_kind_v4;
   logic [KIND_W-1:0]  in_kind;
   logic [KEY_W-1:0]   in_key;
   logic               byp;
   logic               byp_allowed;
   logic [2:0]         byte_idx;
   logic [7:0]         byte_val;
   logic [2*HASH_W-1:0] hash_prod;
   logic               hash_last;
   logic [REM_W-1:0]   rem_shift;
   logic [REM_W-1:0]   rem_sub;
   logic [SET_AW-1:0]  rem_next;
   logic [SET_AW-1:0]  set_pow2;
   logic [WAY_W-1:0]   scan_way;
   entry_type          scan_e;
   logic [BURST_W-1:0] burst_eff;
   logic [TOKEN_W-1:0] cap;
   entry_type          cur_e;
   entry_type          dec_e;
   logic [WAY_W-1:0]   dec_way;
   logic               dec_allowed;
   logic [OUTC_W-1:0]  dec_outcome;
   logic               dec_bucket;
   logic               dec_write;
   logic               sat_full;
   logic [TOKEN_W-1:0] sat_tokens;
   logic [TOKEN_W-1:0] cap_room;

   // Configuration writes; any listed register restarts the clearing pass.
   assign cfg_hit = csr_we && (csr_index == CSR_REFILL_RATE || csr_index == CSR_BURST_SIZE ||
                               csr_index == CSR_MAX_CONNS);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= '0;
         burst_ff     <= '0;
         max_conns_ff <= MAX_CONNS_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_REFILL_RATE) rate_ff <= csr_wdata[RATE_W-1:0];
         if (csr_index == CSR_BURST_SIZE) burst_ff <= csr_wdata[BURST_W-1:0];
         if (csr_index == CSR_MAX_CONNS) max_conns_ff <= csr_wdata[CONN_W-1:0];
      end
   end

   // Source key: IPv4, IPv4-mapped IPv6 as IPv4, or the IPv6 /64 prefix.
   always_comb begin
      in_kind_v4 = (req_if.family == FAM_V4) ||
                   (req_if.addr_hi == '0 && req_if.addr_lo[63:32] == 32'h0000_FFFF);
      in_kind    = in_kind_v4 ? KIND_V4 : KIND_V6;
      in_key     = in_kind_v4 ? {32'd0, req_if.addr_lo[31:0]} : req_if.addr_hi;
   end

   // Words that never touch the table.
   always_comb begin
      byp         = 1'b0;
      byp_allowed = 1'b0;
      priority if (req_if.mode == MODE_NONE) begin
         byp = 1'b1;
      end else if (req_if.family != FAM_V4 && req_if.family != FAM_V6) begin
         byp         = 1'b1;
         byp_allowed = (req_if.mode != MODE_CLOSE);
      end else if (req_if.mode == MODE_QUERY && rate_ff == '0) begin
         byp         = 1'b1;
         byp_allowed = 1'b1;
      end
   end

   // One FNV-1a byte per cycle; the IPv6 key is followed by eight zero bytes.
   always_comb begin
      byte_idx  = (kind_ff == KIND_V4) ? {1'b0, 2'd3 - step_ff[1:0]} : 3'd7 - step_ff[2:0];
      byte_val  = (kind_ff == KIND_V6 && step_ff[3]) ? 8'd0 : key_ff[{byte_idx, 3'b000} +: 8];
      hash_prod = {32'd0, hash_ff ^ {24'd0, byte_val}} * {32'd0, FNV_PRIME};
      hash_last = (step_ff == ((kind_ff == KIND_V4) ? V4_LAST_BYTE : V6_LAST_BYTE));
   end

   // Set index: a mask when the set count is a power of two, else one remainder bit a cycle.
   // The mask is taken from the hash value that the last byte step produces.
   always_comb begin
      rem_shift = {rem_ff, hash_ff[MOD_LAST_STEP - step_ff]};
      rem_sub   = rem_shift - REM_W'(SETS);
      rem_next  = (rem_shift >= REM_W'(SETS)) ? rem_sub[SET_AW-1:0] : rem_shift[SET_AW-1:0];
      set_pow2  = SET_AW'(hash_prod[HASH_W-1:0] & HASH_W'(SETS - 1));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_if.mode;
         kind_ff <= in_kind;
         key_ff  <= in_key;
         now_ff  <= req_if.now_time;
         hash_ff <= FNV_BASIS;
      end else if (cmd.hash_step) begin
         hash_ff <= hash_prod[HASH_W-1:0];
      end
      if (cmd.hash_step && hash_last) begin
         rem_ff <= '0;
         set_ff <= set_pow2;
      end else if (cmd.mod_step) begin
         rem_ff <= rem_next;
         set_ff <= rem_next;
      end
   end

   // Shared step counter for hash bytes, remainder bits and ways.
   always_ff @(posedge clock) begin
      if (reset || cmd.step_clr) begin
         step_ff <= '0;
      end else if (cmd.hash_step || cmd.mod_step || cmd.scan_step) begin
         step_ff <= step_ff + 5'd1;
      end
   end

   // Clearing pass row counter.
   always_ff @(posedge clock) begin
      if (reset || cmd.clr_start) begin
         clr_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // Table memory: one write port, one registered read.
   always_comb begin
      wrow          = row_ff;
      wrow[way_ff]  = ent_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_write) begin
         mem[clr_ff] <= '0;
      end else if (cmd.mem_write) begin
         mem[set_ff] <= wrow;
      end
      if (cmd.read) begin
         row_ff <= mem[set_ff];
      end
   end

   // Way scan: first match, first empty way, oldest way without connections.
   assign scan_way = step_ff[WAY_W-1:0];
   assign scan_e   = row_ff[scan_way];

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         found_ff       <= 1'b0;
         empty_found_ff <= 1'b0;
         idle_found_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         if (!found_ff && scan_e.kind == kind_ff && scan_e.key == key_ff) begin
            found_ff   <= 1'b1;
            hit_way_ff <= scan_way;
         end
         if (scan_e.kind == KIND_EMPTY) begin
            if (!empty_found_ff) begin
               empty_found_ff <= 1'b1;
               empty_way_ff   <= scan_way;
            end
         end else if (scan_e.conns == '0 &&
                      (!idle_found_ff || scan_e.last_time < idle_last_ff)) begin
            idle_found_ff <= 1'b1;
            idle_way_ff   <= scan_way;
            idle_last_ff  <= scan_e.last_time;
         end
      end
   end

   // Bucket capacity in Q.16.
   always_comb begin
      burst_eff = (burst_ff != '0) ? burst_ff : {rate_ff, 1'b0};
      cap       = {1'b0, burst_eff, 16'd0};
   end

   // Decision after the scan.
   always_comb begin
      cur_e       = row_ff[hit_way_ff];
      dec_e       = cur_e;
      dec_way     = hit_way_ff;
      dec_allowed = 1'b0;
      dec_outcome = OUTC_NO_SLOT;
      dec_bucket  = 1'b0;
      dec_write   = 1'b0;
      if (mode_ff == MODE_CLOSE) begin
         if (found_ff) begin
            dec_outcome = OUTC_EXISTING;
            dec_write   = 1'b1;
            if (cur_e.conns != '0) dec_e.conns = cur_e.conns - 8'd1;
         end
      end else if (!found_ff && !empty_found_ff && !idle_found_ff) begin
         dec_allowed = (mode_ff == MODE_QUERY);
      end else begin
         dec_write = 1'b1;
         if (!found_ff) begin
            dec_way         = empty_found_ff ? empty_way_ff : idle_way_ff;
            dec_e.kind      = kind_ff;
            dec_e.key       = key_ff;
            dec_e.tokens    = cap;
            dec_e.last_time = now_ff;
            dec_e.conns     = '0;
            dec_outcome     = OUTC_NEW;
         end else begin
            dec_outcome = OUTC_EXISTING;
         end
         if (mode_ff == MODE_OPEN) begin
            if (dec_e.conns < max_conns_ff) begin
               dec_e.conns = dec_e.conns + 8'd1;
               dec_allowed = 1'b1;
            end
         end else if (found_ff) begin
            dec_bucket = 1'b1;
         end else if (dec_e.tokens >= ONE_TOKEN) begin
            dec_e.tokens = dec_e.tokens - ONE_TOKEN;
            dec_allowed  = 1'b1;
         end
      end
   end

   // Refill, saturation at capacity, and the spend of one token.
   always_comb begin
      cap_room   = cap - ent_ff.tokens;
      sat_full   = (ent_ff.tokens >= cap) || (add_ff[ADD_W-1:TOKEN_W] != '0) ||
                   (add_ff[TOKEN_W-1:0] >= cap_room);
      sat_tokens = sat_full ? cap : ent_ff.tokens + add_ff[TOKEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         allowed_ff <= byp_allowed;
         outcome_ff <= OUTC_BYPASS;
      end else if (cmd.decide) begin
         ent_ff     <= dec_e;
         way_ff     <= dec_way;
         allowed_ff <= dec_allowed;
         outcome_ff <= dec_outcome;
      end else if (cmd.sat) begin
         ent_ff.last_time <= now_ff;
         if (sat_tokens >= ONE_TOKEN) begin
            ent_ff.tokens <= sat_tokens - ONE_TOKEN;
            allowed_ff    <= 1'b1;
         end else begin
            ent_ff.tokens <= sat_tokens;
            allowed_ff    <= 1'b0;
         end
      end
      if (cmd.elapsed) begin
         elapsed_ff <= (now_ff > ent_ff.last_time) ? now_ff - ent_ff.last_time : '0;
      end
      if (cmd.mul_lo) begin
         plo_ff <= {16'd0, elapsed_ff[HALF_T_W-1:0]} * {24'd0, rate_ff};
      end
      if (cmd.mul_hi) begin
         phi_ff <= {16'd0, elapsed_ff[TIME_W-1:HALF_T_W]} * {24'd0, rate_ff};
      end
      if (cmd.sum) begin
         add_ff <= {24'd0, plo_ff} + {phi_ff, 24'd0};
      end
   end

   // Output register parts the response side from the work in progress.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_allowed_ff <= allowed_ff;
         rsp_outcome_ff <= outcome_ff;
      end
   end

   assign req_if.ready   = cmd.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.allowed = rsp_allowed_ff;
   assign rsp_if.outcome = rsp_outcome_ff;

   // Status to the controller.
   always_comb begin
      status             = '0;
      status.req_valid   = req_if.valid;
      status.bypass      = byp;
      status.cfg_hit     = cfg_hit;
      status.hash_last   = hash_last;
      status.mod_last    = (step_ff == MOD_LAST_STEP);
      status.scan_last   = (step_ff == STEP_W'(TABLE_WAYS - 1));
      status.sets_pow2   = SETS_POW2;
      status.need_bucket = dec_bucket;
      status.need_write  = dec_write;
      status.out_free    = !rsp_valid_ff || rsp_if.ready;
      status.clr_last    = (clr_ff == SET_AW'(SETS - 1));
   end

endmodule

### hw/rtl/per_source_token_bucket_limiter.sv
// Top level of the per-source token bucket and connection limiter.
//
//   channel  direction  handshake          payload
//   req_if   in         valid/ready        mode, family, addr_hi, addr_lo, now_time
//   rsp_if   out        valid/ready        allowed, outcome
//   csr      in         csr_we, no ready   csr_index, csr_wdata
//
// One word is worked at a time; a bypassed word goes from idle to done. A table word
// passes idle, an FNV-1a step per key byte (4 for IPv4, 16 for IPv6), 32 remainder steps
// unless the set count is a power of two, read, a scan step per way, decide, write and
// done; a query that hits adds elapsed, low and high multiply, sum and saturate, and
// write is skipped if nothing is written back (a close with no match, or no free slot).
// After reset and after each register write a clearing pass writes one set row a cycle,
// all TABLE_SLOTS / TABLE_WAYS rows (1024 by default), before words are taken. A new
// word is taken while the previous response still waits in the output register.
`timescale 1ns / 1ps
module per_source_token_bucket_limiter #(
   parameter int TABLE_SLOTS = pstbl_pkg::DEF_TABLE_SLOTS,
   parameter int TABLE_WAYS  = pstbl_pkg::DEF_TABLE_WAYS
) (
   input  logic                             clock,
   input  logic                             reset,
   pstbl_req_if.sink                        req_if,
   pstbl_rsp_if.source                      rsp_if,
   input  logic                             csr_we,
   input  logic [pstbl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pstbl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pstbl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer.
   pstbl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // Hash, table and bucket datapath.
   pstbl_dp #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .TABLE_WAYS  (TABLE_WAYS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### tb/sv/pstbl_checker.sv
// Checker of the limiter: predicts every response and compares it with the block's output.
`timescale 1ns / 1ps
module pstbl_checker
   import pstbl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   pstbl_req_if                  req_if,
   pstbl_rsp_if                  rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   localparam int SLOTS = DEF_TABLE_SLOTS;
   localparam int WAYS  = DEF_TABLE_WAYS;
   localparam int SETS  = SLOTS / WAYS;

   typedef struct packed {
      logic              allowed;
      logic [OUTC_W-1:0] outcome;
   } verdict_type;

   verdict_type verdict_q[$];

   // Shadow copy of the registers and the table.
   logic [RATE_W-1:0]  rate;
   logic [BURST_W-1:0] burst;
   logic [CONN_W-1:0]  conn_cap;
   logic [KIND_W-1:0]  kind_mem[SLOTS];
   logic [KEY_W-1:0]   key_mem[SLOTS];
   logic [TOKEN_W-1:0] tokens_mem[SLOTS];
   logic [TIME_W-1:0]  last_mem[SLOTS];
   logic [CONN_W-1:0]  conns_mem[SLOTS];

   // First way of the set that a key hashes to.
   function automatic int set_base(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
      logic [HASH_W-1:0] h;
      logic [7:0]        b;
      int                nb;
      int                total;
      h = FNV_BASIS;
      nb = (kind == KIND_V4) ? 4 : 8;
      total = (kind == KIND_V4) ? 4 : 16;
      for (int i = 0; i < total; i++) begin
         b = (i < nb) ? 8'(key >> (8 * (nb - 1 - i))) : 8'h00;
         h = h ^ {24'h0, b};
         h = h * FNV_PRIME;
      end
      return int'(h % 32'(SETS)) * WAYS;
   endfunction

   function automatic logic [TOKEN_W-1:0] bucket_cap();
      logic [17:0] b;
      b = (burst != 0) ? {1'b0, burst} : {1'b0, rate, 1'b0};
      return TOKEN_W'({b, 16'h0000});
   endfunction

   task automatic clear_table();
      for (int i = 0; i < SLOTS; i++) begin
         kind_mem[i] = KIND_EMPTY;
         key_mem[i] = '0;
         tokens_mem[i] = '0;
         last_mem[i] = '0;
         conns_mem[i] = '0;
      end
   endtask

   // Works out the response to one word and updates the shadow table.
   task automatic predict_verdict(input logic [MODE_W-1:0] mode,
                                  input logic [FAMILY_W-1:0] family,
                                  input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                                  input logic [TIME_W-1:0] now,
                                  output verdict_type v);
      logic [KIND_W-1:0]  kind;
      logic [KEY_W-1:0]   key;
      logic [TOKEN_W-1:0] cap;
      logic [TOKEN_W-1:0] t;
      logic [TIME_W-1:0]  elapsed;
      logic [63:0]        add;
      int                 base;
      int                 s;
      int                 empty;
      int                 idle;
      bit                 fresh;
      v.allowed = 1'b0;
      v.outcome = OUTC_BYPASS;
      fresh = 0;
      if (mode == MODE_NONE) return;
      if (family != FAM_V4 && family != FAM_V6) begin
         v.allowed = (mode != MODE_CLOSE);
         return;
      end
      if (mode == MODE_QUERY && rate == 0) begin
         v.allowed = 1'b1;
         return;
      end
      // Mapped IPv6 addresses fold onto the IPv4 key.
      if (family == FAM_V4 || (hi == 0 && lo[63:32] == 32'h0000ffff)) begin
         kind = KIND_V4;
         key = {32'h0, lo[31:0]};
      end else begin
         kind = KIND_V6;
         key = hi;
      end
      base = set_base(kind, key);
      s = -1;
      for (int w = 0; w < WAYS; w++)
         if (s < 0 && kind_mem[base+w] == kind && key_mem[base+w] == key) s = base + w;
      if (mode == MODE_CLOSE) begin
         if (s < 0) begin
            v.outcome = OUTC_NO_SLOT;
         end else begin
            if (conns_mem[s] > 0) conns_mem[s]--;
            v.outcome = OUTC_EXISTING;
         end
         return;
      end
      // Miss: first empty way, else the oldest way with no connections.
      if (s < 0) begin
         fresh = 1;
         empty = -1;
         idle = -1;
         for (int w = 0; w < WAYS; w++) begin
            if (kind_mem[base+w] == KIND_EMPTY) begin
               if (empty < 0) empty = base + w;
            end else if (conns_mem[base+w] == 0 &&
                         (idle < 0 || last_mem[base+w] < last_mem[idle])) begin
               idle = base + w;
            end
         end
         s = (empty >= 0) ? empty : idle;
         if (s >= 0) begin
            kind_mem[s] = kind;
            key_mem[s] = key;
            tokens_mem[s] = bucket_cap();
            last_mem[s] = now;
            conns_mem[s] = '0;
         end
      end
      if (s < 0) begin
         v.allowed = (mode == MODE_QUERY);
         v.outcome = OUTC_NO_SLOT;
         return;
      end
      v.outcome = fresh ? OUTC_NEW : OUTC_EXISTING;
      if (mode == MODE_OPEN) begin
         if (conns_mem[s] < conn_cap) begin
            conns_mem[s]++;
            v.allowed = 1'b1;
         end
         return;
      end
      // Query: refill by elapsed time, saturate, then spend one token.
      if (!fresh) begin
         cap = bucket_cap();
         elapsed = (now > last_mem[s]) ? now - last_mem[s] : '0;
         add = 64'(elapsed) * 64'(rate);
         t = tokens_mem[s];
         if (t >= cap || add >= 64'(cap - t)) t = cap;
         else t = t + TOKEN_W'(add);
         tokens_mem[s] = t;
         last_mem[s] = now;
      end
      if (tokens_mem[s] >= ONE_TOKEN) begin
         tokens_mem[s] = tokens_mem[s] - ONE_TOKEN;
         v.allowed = 1'b1;
      end
   endtask

   // Register writes, accepted words and responses, all sampled at the edge.
   always @(posedge clock) begin
      verdict_type v;
      verdict_type got;
      if (reset) begin
         rate = '0;
         burst = '0;
         conn_cap = MAX_CONNS_RESET;
         clear_table();
         verdict_q.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_REFILL_RATE) rate = csr_wdata[RATE_W-1:0];
            else if (csr_index == CSR_BURST_SIZE) burst = csr_wdata[BURST_W-1:0];
            else if (csr_index == CSR_MAX_CONNS) conn_cap = csr_wdata[CONN_W-1:0];
            if (csr_index == CSR_REFILL_RATE || csr_index == CSR_BURST_SIZE ||
                csr_index == CSR_MAX_CONNS) clear_table();
         end
         if (req_if.valid && req_if.ready) begin
            predict_verdict(req_if.mode, req_if.family, req_if.addr_hi, req_if.addr_lo,
                            req_if.now_time, v);
            verdict_q.push_back(v);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.allowed = rsp_if.allowed;
            got.outcome = rsp_if.outcome;
            if (verdict_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response: allowed %0d outcome %0d",
                           got.allowed, got.outcome);
               fail_count <= fail_count + 1;
            end else begin
               v = verdict_q.pop_front();
               if (got != v) begin
                  if (fail_count < 10)
                     $display("response mismatch: expected allowed %0d outcome %0d, got %0d %0d",
                              v.allowed, v.outcome, got.allowed, got.outcome);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      outstanding <= verdict_q.size();
   end

endmodule

### tb/sv/tb_per_source_token_bucket_limiter.sv
// Testbench top of the limiter: clock, reset, stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_per_source_token_bucket_limiter;
   import pstbl_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE = 80;
   localparam int PHASES = 6;
   localparam int WORDS_PER_PHASE = 215;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    outstanding;
   int                    cycles;
   bit                    calm;

   logic [31:0]       v4_pool[8];
   logic [63:0]       v6_pool[4];
   logic [TIME_W-1:0] now_t;

   pstbl_req_if req_if ();
   pstbl_rsp_if rsp_if ();

   per_source_token_bucket_limiter dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pstbl_checker chk (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The response side stalls at random except in the calm stretch.
   always @(posedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(99) >= 21);
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("per_source_token_bucket_limiter verification failed");
         $finish;
      end
   end

   // Sends one word, with a random gap ahead of it outside the calm stretch.
   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [FAMILY_W-1:0] family,
                            input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                            input logic [TIME_W-1:0] now);
      if (!calm && $urandom_range(99) < 21) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= mode;
      req_if.family <= family;
      req_if.addr_hi <= hi;
      req_if.addr_lo <= lo;
      req_if.now_time <= now;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Waits until the block is idle, then writes one register.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Six IPv4 keys share one set so that claims, evictions and full sets happen.
   task automatic fill_pools();
      int target;
      logic [31:0] cand;
      v4_pool[0] = $urandom;
      target = chk.set_base(KIND_V4, {32'h0, v4_pool[0]});
      for (int k = 1; k < 6; k++) begin
         do cand = $urandom;
         while (chk.set_base(KIND_V4, {32'h0, cand}) != target || cand == v4_pool[0]);
         v4_pool[k] = cand;
      end
      v4_pool[6] = $urandom;
      v4_pool[7] = $urandom;
      for (int k = 0; k < 4; k++) v6_pool[k] = {$urandom, $urandom};
   endtask

   // One random word: mostly pooled keys, some foreign families and unused modes.
   task automatic random_word();
      logic [MODE_W-1:0]   mode;
      logic [FAMILY_W-1:0] family;
      logic [ADDR_W-1:0]   hi;
      logic [ADDR_W-1:0]   lo;
      int                  r;
      logic [31:0]         v4;
      r = $urandom_range(99);
      mode = (r < 50) ? MODE_QUERY : (r < 75) ? MODE_OPEN : (r < 97) ? MODE_CLOSE : MODE_NONE;
      v4 = v4_pool[$urandom_range(7)];
      r = $urandom_range(99);
      if (r < 55) begin
         family = FAM_V4;
         hi = {$urandom, $urandom};
         lo = {$urandom, v4};
      end else if (r < 75) begin
         family = FAM_V6;
         hi = '0;
         lo = {32'h0000ffff, v4};
      end else if (r < 95) begin
         family = FAM_V6;
         hi = v6_pool[$urandom_range(3)];
         lo = {$urandom, $urandom};
      end else begin
         family = FAMILY_W'($urandom_range(2, 3));
         hi = {$urandom, $urandom};
         lo = {$urandom, $urandom};
      end
      r = $urandom_range(99);
      if (r < 5) now_t = now_t - TIME_W'($urandom_range(50000));
      else if (r < 8) now_t = now_t + TIME_W'($urandom_range(2000000));
      else now_t = now_t + TIME_W'($urandom_range(30000));
      send_word(mode, family, hi, lo, now_t);
   endtask

   initial begin
      logic [RATE_W-1:0]  rates[PHASES];
      logic [BURST_W-1:0] bursts[PHASES];
      logic [CONN_W-1:0]  caps[PHASES];
      logic [63:0]        a4;
      rates  = '{16'd1, 16'd65535, 16'd3, 16'd200, 16'd0, 16'd20000};
      bursts = '{17'd0, 17'd131070, 17'd2, 17'd0, 17'd7, 17'd1};
      caps   = '{8'd2, 8'd255, 8'd1, 8'd4, 8'd16, 8'd3};
      cycles = 0;
      calm = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.mode = MODE_QUERY;
      req_if.family = FAM_V4;
      req_if.addr_hi = '0;
      req_if.addr_lo = '0;
      req_if.now_time = '0;
      rsp_if.ready = 1'b0;
      fill_pools();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words under reset settings: query limiting off.
      a4 = {32'h0, v4_pool[6]};
      send_word(MODE_QUERY, FAM_V4, '0, a4, '0);
      send_word(MODE_OPEN, FAM_V4, '0, a4, '0);
      send_word(MODE_OPEN, FAM_V4, '1, {32'hffffffff, v4_pool[6]}, 48'd5);
      send_word(MODE_CLOSE, FAM_V4, '0, a4, 48'd6);
      send_word(MODE_CLOSE, FAM_V4, '0, a4, 48'd7);
      send_word(MODE_CLOSE, FAM_V4, '0, a4, 48'd8);
      send_word(MODE_CLOSE, FAM_V6, '1, '1, 48'd9);
      send_word(MODE_NONE, FAM_V4, '0, a4, '1);
      send_word(MODE_QUERY, 2'd2, '1, '1, '1);
      send_word(MODE_OPEN, 2'd3, '0, '0, '0);
      send_word(MODE_CLOSE, 2'd3, '0, '0, '0);

      // Directed words with a slow bucket and a cap of two connections.
      write_reg(CSR_REFILL_RATE, 17'(rates[0]));
      write_reg(CSR_BURST_SIZE, bursts[0]);
      write_reg(CSR_MAX_CONNS, 17'(caps[0]));
      now_t = 48'd1000;
      send_word(MODE_QUERY, FAM_V4, '0, a4, now_t);
      send_word(MODE_QUERY, FAM_V6, '0, {32'h0000ffff, v4_pool[6]}, now_t);
      send_word(MODE_QUERY, FAM_V4, '1, {32'hdeadbeef, v4_pool[6]}, now_t);
      send_word(MODE_QUERY, FAM_V4, '0, a4, now_t + 48'd65536);
      send_word(MODE_QUERY, FAM_V4, '0, a4, now_t);
      send_word(MODE_QUERY, FAM_V6, '1, '0, now_t);
      for (int k = 0; k < 3; k++) send_word(MODE_OPEN, FAM_V6, '1, '1, now_t);
      // Pin four colliding keys with open connections, then a fifth finds no slot.
      for (int k = 0; k < 4; k++) send_word(MODE_OPEN, FAM_V4, '0, {32'h0, v4_pool[k]}, now_t);
      send_word(MODE_QUERY, FAM_V4, '0, {32'h0, v4_pool[4]}, now_t);
      send_word(MODE_OPEN, FAM_V4, '0, {32'h0, v4_pool[4]}, now_t);

      // Random phases over a range of register settings.
      for (int p = 0; p < PHASES; p++) begin
         write_reg(CSR_REFILL_RATE, 17'(rates[p]));
         write_reg(CSR_BURST_SIZE, bursts[p]);
         write_reg(CSR_MAX_CONNS, 17'(caps[p]));
         fill_pools();
         now_t = {16'($urandom_range(65535)), 32'($urandom)};
         if (p == 2) now_t = 48'hffff_fff0_0000;
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            calm = (p == 3 && n >= 50 && n < 170);
            random_word();
         end
         calm = 0;
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("per_source_token_bucket_limiter verification clean");
      end else begin
         $display("per_source_token_bucket_limiter verification failed");
      end
      $finish;
   end

endmodule
